// ===== rtl/kart_pkg.sv =====
// ----------------------------------------------------------------------------
// kart_pkg: shared types and constants for the angle/rate tracker
// Payload structs, register indexes and fixed-point constants.
// ----------------------------------------------------------------------------
package kart_pkg;

    localparam int FRAC_BITS = 16;
    localparam int REG_W     = 31;
    localparam int IDX_W     = 3;

    typedef struct packed {
        logic signed [31:0] gimbal_angle;
        logic signed [31:0] vision_offset;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] aim_angle;
        logic signed [31:0] filtered_angle;
        logic signed [31:0] filtered_rate;
    } t_out_item;

    localparam logic [IDX_W-1:0] REG_Q_ANGLE = 3'd0;
    localparam logic [IDX_W-1:0] REG_Q_RATE  = 3'd1;
    localparam logic [IDX_W-1:0] REG_R_MEAS  = 3'd2;
    localparam logic [IDX_W-1:0] REG_DT      = 3'd3;
    localparam logic [IDX_W-1:0] REG_LEAD    = 3'd4;

    localparam logic signed [31:0] ONE_FX   = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [31:0] LIM_FX   = 32'sd5 <<< FRAC_BITS;
    localparam logic signed [31:0] VIS_THR  = 32'sd15 <<< FRAC_BITS;
    localparam logic signed [31:0] P00_RST  = 32'sd10 <<< FRAC_BITS;
    localparam logic signed [31:0] P11_RST  = ONE_FX >>> 1;
    localparam logic [REG_W-1:0]   QA_RST   = REG_W'(50 * (1 << FRAC_BITS));
    localparam logic [REG_W-1:0]   HUND_RST = REG_W'((1 << FRAC_BITS) / 100);
    localparam logic [REG_W-1:0]   DT_RST   = REG_W'(1 << FRAC_BITS);
    localparam logic [REG_W-1:0]   LEAD_RST = REG_W'(120 * (1 << FRAC_BITS));

    // saturate a 34-bit sum to 32 bits
    function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
        logic signed [33:0] hi;
        logic signed [33:0] lo;
        hi = 34'sd2147483647;
        lo = -34'sd2147483648;
        if (v > hi) return 32'sh7fffffff;
        if (v < lo) return 32'sh80000000;
        return v[31:0];
    endfunction

    // signed result from magnitude, clamped to range
    function automatic logic signed [31:0] from_mag(input logic [63:0] m,
                                                    input logic neg);
        if (neg) begin
            if (m >= 64'h8000_0000) return 32'sh80000000;
            return -($signed({1'b0, m[30:0]}));
        end
        if (m > 64'h7fff_ffff) return 32'sh7fffffff;
        return $signed({1'b0, m[30:0]});
    endfunction

endpackage

// ===== rtl/kalman_angle_rate_tracker.sv =====
// ----------------------------------------------------------------------------
// kalman_angle_rate_tracker: two-state constant-velocity tracker
// Predict, gain, update and covariance steps run on one shared multiplier,
// one shared adder and a bit-serial divider under a small sequencer.
// ----------------------------------------------------------------------------
//  channel | signals                        | direction
//  in      | i_valid / o_ready / i_in       | item in
//  out     | o_valid / i_ready / o_out      | item out
//  cfg     | i_cfg_we / i_cfg_idx / i_cfg_data | register write
//
// One item runs from acceptance to o_valid through 12 multiplies, 16 adds, two
// 48-step restoring divisions (skipped with a zero result when the denominator
// is zero) and a final load of the result; o_ready is back high in the cycle
// o_valid rises.
// Reset restores estimate, covariance and registers at once. A finished item
// waits in the last state only while the previous result is still held.
module kalman_angle_rate_tracker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  kart_pkg::t_in_item            i_in,
    output logic                          o_valid,
    input  logic                          i_ready,
    output kart_pkg::t_out_item           o_out,
    input  logic                          i_cfg_we,
    input  logic [kart_pkg::IDX_W-1:0]    i_cfg_idx,
    input  logic [kart_pkg::REG_W-1:0]    i_cfg_data
);

    typedef enum logic [2:0] {S_IDLE, S_MUL, S_ADD, S_DIV, S_DONE} t_state;

    localparam int DIV_W = 32 + kart_pkg::FRAC_BITS;

    // register file slots
    typedef enum logic [4:0] {
        V_X0, V_X1, V_P00, V_P01, V_P10, V_P11, V_DT, V_QA, V_QR, V_R, V_LT,
        V_G, V_VIS, V_ONE, V_ZERO, V_T, V_XP0, V_T00, V_T01, V_PP00, V_PP10,
        V_PP11, V_DEN, V_K0, V_K1, V_IN, V_M00, V_NK1, V_LEAD, V_ANG
    } t_slot;

    typedef enum logic [1:0] {OP_MUL, OP_ADD, OP_SUB, OP_DIV} t_op;

    typedef struct packed {
        t_op   op;
        t_slot a;
        t_slot b;
        t_slot d;
    } t_uop;

    function automatic t_uop prog(input logic [5:0] pc);
        t_uop u;
        u = '{OP_ADD, V_ZERO, V_ZERO, V_T};
        case (pc)
            6'd0:  u = '{OP_MUL, V_X1,   V_DT,   V_T};
            6'd1:  u = '{OP_ADD, V_X0,   V_T,    V_XP0};
            6'd2:  u = '{OP_MUL, V_DT,   V_P10,  V_T};
            6'd3:  u = '{OP_ADD, V_P00,  V_T,    V_T00};
            6'd4:  u = '{OP_MUL, V_DT,   V_P11,  V_T};
            6'd5:  u = '{OP_ADD, V_P01,  V_T,    V_T01};
            6'd6:  u = '{OP_MUL, V_T01,  V_DT,   V_T};
            6'd7:  u = '{OP_ADD, V_T00,  V_T,    V_PP00};
            6'd8:  u = '{OP_ADD, V_PP00, V_QA,   V_PP00};
            6'd9:  u = '{OP_MUL, V_P11,  V_DT,   V_T};
            6'd10: u = '{OP_ADD, V_P10,  V_T,    V_PP10};
            6'd11: u = '{OP_ADD, V_P11,  V_QR,   V_PP11};
            6'd12: u = '{OP_ADD, V_PP00, V_R,    V_DEN};
            6'd13: u = '{OP_DIV, V_PP00, V_DEN,  V_K0};
            6'd14: u = '{OP_DIV, V_PP10, V_DEN,  V_K1};
            6'd15: u = '{OP_ADD, V_G,    V_VIS,  V_IN};
            6'd16: u = '{OP_SUB, V_IN,   V_XP0,  V_IN};
            6'd17: u = '{OP_MUL, V_K0,   V_IN,   V_T};
            6'd18: u = '{OP_ADD, V_XP0,  V_T,    V_X0};
            6'd19: u = '{OP_MUL, V_K1,   V_IN,   V_T};
            6'd20: u = '{OP_ADD, V_X1,   V_T,    V_X1};
            6'd21: u = '{OP_SUB, V_ONE,  V_K0,   V_M00};
            6'd22: u = '{OP_SUB, V_ZERO, V_K1,   V_NK1};
            6'd23: u = '{OP_MUL, V_M00,  V_PP00, V_P00};
            6'd24: u = '{OP_MUL, V_M00,  V_T01,  V_P01};
            6'd25: u = '{OP_MUL, V_NK1,  V_PP00, V_T};
            6'd26: u = '{OP_ADD, V_T,    V_PP10, V_P10};
            6'd27: u = '{OP_MUL, V_NK1,  V_T01,  V_T};
            6'd28: u = '{OP_ADD, V_T,    V_PP11, V_P11};
            6'd29: u = '{OP_MUL, V_X1,   V_LT,   V_LEAD};
            default: u = '{OP_ADD, V_ZERO, V_ZERO, V_T};
        endcase
        return u;
    endfunction

    localparam logic [5:0] PC_LAST = 6'd29;

    // lead / 10 as a multiply by the rounded-up reciprocal
    localparam int DIV10_SH = kart_pkg::FRAC_BITS + 10;
    localparam int LO_W     = kart_pkg::FRAC_BITS + 6;
    localparam int M_W      = kart_pkg::FRAC_BITS + 7;
    localparam logic [M_W-1:0] DIV10_M =
        M_W'(((64'd1 << DIV10_SH) + 64'd9) / 64'd10);
    localparam logic [31:0] TENTH_CAP = 32'(64'd50 << kart_pkg::FRAC_BITS);

    t_state r_state, n_state;
    logic [5:0] r_pc;
    logic signed [31:0] r_v [0:29];
    logic [kart_pkg::REG_W-1:0] r_qa, r_qr, r_r, r_dt, r_lt;
    logic signed [31:0] r_g, r_vis;
    logic r_ph;
    logic signed [63:0] r_prod;
    // divider
    logic [DIV_W-1:0] r_quo;
    logic [32:0]      r_rem;
    logic [31:0]      r_dvs;
    logic [5:0]       r_dcnt;
    logic             r_dneg;
    logic             r_valid;
    kart_pkg::t_out_item r_out;

    t_uop u;
    logic signed [31:0] opa, opb;
    logic [63:0] pmag, prnd;
    logic signed [31:0] mul_res, add_res;
    logic [32:0] rem_sh, rem_sub;
    logic out_load;

    function automatic logic signed [31:0] rd(input t_slot s,
        input logic signed [31:0] v [0:29],
        input logic [kart_pkg::REG_W-1:0] dt, qa, qr, rr, lt,
        input logic signed [31:0] g, vis);
        case (s)
            V_DT:   return $signed({1'b0, dt});
            V_QA:   return $signed({1'b0, qa});
            V_QR:   return $signed({1'b0, qr});
            V_R:    return $signed({1'b0, rr});
            V_LT:   return $signed({1'b0, lt});
            V_G:    return g;
            V_VIS:  return vis;
            V_ONE:  return kart_pkg::ONE_FX;
            V_ZERO: return 32'sd0;
            default: return v[s];
        endcase
    endfunction

    always_comb begin
        u   = prog(r_pc);
        opa = rd(u.a, r_v, r_dt, r_qa, r_qr, r_r, r_lt, r_g, r_vis);
        opb = rd(u.b, r_v, r_dt, r_qa, r_qr, r_r, r_lt, r_g, r_vis);
        pmag = r_prod[63] ? 64'(-r_prod) : 64'(r_prod);
        prnd = (pmag + (64'd1 << (kart_pkg::FRAC_BITS - 1))) >> kart_pkg::FRAC_BITS;
        mul_res = kart_pkg::from_mag(prnd, r_prod[63]);
        if (u.op == OP_SUB)
            add_res = kart_pkg::sat34(34'(opa) - 34'(opb));
        else
            add_res = kart_pkg::sat34(34'(opa) + 34'(opb));
        rem_sh  = {r_rem[31:0], r_quo[DIV_W-1]};
        rem_sub = rem_sh - {1'b0, r_dvs};
    end

    // result register takes the item unless the previous one is still held
    assign out_load = (r_state == S_DONE) && (!r_valid || i_ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_valid && o_ready) n_state = S_ADD;
            S_ADD:  if (u.op == OP_MUL) n_state = S_MUL;
                    else if (u.op == OP_DIV && opb != 32'sd0) n_state = S_DIV;
                    else if (r_pc == PC_LAST) n_state = S_DONE;
            S_MUL:  if (r_ph) n_state = (r_pc == PC_LAST) ? S_DONE : S_ADD;
            S_DIV:  if (r_dcnt == 6'd0) n_state = S_ADD;
            S_DONE: if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    logic signed [31:0] lead_s, lead_c, ang_new;
    logic [31:0] lead_mag, lead_tenth;
    logic [LO_W+M_W-1:0] lead_q;
    always_comb begin
        lead_s = r_v[V_LEAD];
        lead_mag = lead_s[31] ? 32'(-lead_s) : 32'(lead_s);
        // exact for magnitudes below TENTH_CAP
        lead_q = (LO_W+M_W)'(lead_mag[LO_W-1:0]) * (LO_W+M_W)'(DIV10_M);
        lead_tenth = 32'(lead_q >> DIV10_SH);
        if (r_vis > kart_pkg::VIS_THR) begin
            // a tenth of anything at or above TENTH_CAP lands on the limit anyway
            if (lead_mag >= TENTH_CAP)
                lead_s = lead_s[31] ? -kart_pkg::LIM_FX : kart_pkg::LIM_FX;
            else
                lead_s = lead_s[31] ? -$signed(lead_tenth) : $signed(lead_tenth);
        end
        lead_c = lead_s;
        if (lead_c > kart_pkg::LIM_FX) lead_c = kart_pkg::LIM_FX;
        if (lead_c < -kart_pkg::LIM_FX) lead_c = -kart_pkg::LIM_FX;
        ang_new = r_v[V_X0];
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_valid;
    assign o_out   = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pc    <= '0;
            r_ph    <= 1'b0;
            r_valid <= 1'b0;
            r_dcnt  <= '0;
            r_qa <= kart_pkg::QA_RST;   r_qr <= kart_pkg::HUND_RST;
            r_r  <= kart_pkg::HUND_RST; r_dt <= kart_pkg::DT_RST;
            r_lt <= kart_pkg::LEAD_RST;
            r_v[V_X0]  <= '0;  r_v[V_X1]  <= '0;
            r_v[V_P00] <= kart_pkg::P00_RST; r_v[V_P01] <= '0;
            r_v[V_P10] <= '0;  r_v[V_P11] <= kart_pkg::P11_RST;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    kart_pkg::REG_Q_ANGLE: r_qa <= i_cfg_data;
                    kart_pkg::REG_Q_RATE:  r_qr <= i_cfg_data;
                    kart_pkg::REG_R_MEAS:  r_r  <= i_cfg_data;
                    kart_pkg::REG_DT:      r_dt <= i_cfg_data;
                    kart_pkg::REG_LEAD:    r_lt <= i_cfg_data;
                    default: ;
                endcase
            end
            if (out_load) r_valid <= 1'b1;
            else if (i_ready) r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_valid && o_ready) begin
                    r_g <= i_in.gimbal_angle;
                    r_vis <= i_in.vision_offset;
                    r_pc <= '0;
                end
                S_ADD: begin
                    unique case (u.op)
                        OP_MUL: begin
                            r_prod <= 64'(opa) * 64'(opb);
                            r_ph <= 1'b0;
                        end
                        OP_DIV: begin
                            if (opb == 32'sd0) begin
                                r_v[u.d] <= '0;
                                r_pc <= r_pc + 6'd1;
                            end else begin
                                r_quo <= DIV_W'((opa[31] ? 64'(-64'(opa)) : 64'(opa))
                                         << kart_pkg::FRAC_BITS);
                                r_dvs <= opb[31] ? 32'(-opb) : 32'(opb);
                                r_rem <= '0;
                                r_dneg <= opa[31] ^ opb[31];
                                r_dcnt <= 6'(DIV_W - 1);
                            end
                        end
                        default: begin
                            r_v[u.d] <= add_res;
                            r_pc <= r_pc + 6'd1;
                        end
                    endcase
                end
                S_MUL: begin
                    r_ph <= 1'b1;
                    if (r_ph) begin
                        r_v[u.d] <= mul_res;
                        r_pc <= r_pc + 6'd1;
                    end
                end
                S_DIV: begin
                    if (!rem_sub[32]) begin
                        r_rem <= rem_sub;
                        r_quo <= {r_quo[DIV_W-2:0], 1'b1};
                    end else begin
                        r_rem <= rem_sh;
                        r_quo <= {r_quo[DIV_W-2:0], 1'b0};
                    end
                    r_dcnt <= r_dcnt - 6'd1;
                    if (r_dcnt == 6'd0) begin
                        r_v[u.d] <= kart_pkg::from_mag(64'({r_quo[DIV_W-2:0],
                                    !rem_sub[32]}), r_dneg);
                        r_pc <= r_pc + 6'd1;
                    end
                end
                S_DONE: begin
                    if (out_load) begin
                        r_out.aim_angle <= kart_pkg::sat34(34'(ang_new) + 34'(lead_c));
                        r_out.filtered_angle <= ang_new;
                        r_out.filtered_rate <= r_v[V_X1];
                    end
                end
                default: ;
            endcase
        end
    end

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> (r_state == S_IDLE)) else $error("ready outside idle");
    a_done_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |=> o_valid) else $error("result lost");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_ready) else $error("accept while busy");

endmodule
